/* sv/first_fit_heap_allocator_macros.svh */
// ----------------------------------------------------------------------------
// First-fit heap allocator assertion macros
// Shared property forms for the checker of the allocator ports.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FFHA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("allocator same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define FFHA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("allocator next-cycle check failed");

`endif

/* sv/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// ffha_pkg
// Types, codes and defaults shared by the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned POOL_UNITS_DEF = 4096;
  localparam int unsigned UNIT_BYTES_DEF = 16;

  typedef enum logic [1:0] {
    CMD_ALLOC,
    CMD_ALIGNED,
    CMD_FREE,
    CMD_QUERY
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NOMEM,
    ST_BADALIGN,
    ST_BADFREE
  } status_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_NEED,
    OP_RD_U,
    OP_STEP_U,
    OP_NOMEM,
    OP_ALLOC_HIT,
    OP_WR_LEAD_REST,
    OP_WR_LEAD_HDR,
    OP_WR_TAIL,
    OP_WR_USED,
    OP_RD_H,
    OP_BADFREE,
    OP_H_HIT,
    OP_RD_N,
    OP_MERGE_N,
    OP_RD_Q,
    OP_STEP_Q,
    OP_WR_P,
    OP_CLR_H,
    OP_WR_H,
    OP_ACC,
    OP_TOTALS,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic align_bad;
    logic rel_bad;
    logic u_end;
    logic fit;
    logic space_nz;
    logic tail_split;
    logic hdr_ok;
    logic n_in;
    logic n_free;
    logic h_zero;
    logic q_lt_h;
    logic p_merge;
    logic clr_last;
    logic out_free;
  } dp_stat_t;

endpackage

/* sv/ffha_ram.sv */
// ----------------------------------------------------------------------------
// ffha_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/ffha_datapath.sv */
// ----------------------------------------------------------------------------
// ffha_datapath
// Block table memory, walk pointers, size arithmetic and result registers.
// ----------------------------------------------------------------------------
module ffha_datapath #(
  parameter int unsigned POOL_UNITS = ffha_pkg::POOL_UNITS_DEF,
  parameter int unsigned UNIT_BYTES = ffha_pkg::UNIT_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ffha_pkg::dp_cmd_t cmd_i,
  output ffha_pkg::dp_stat_t stat_o,
  input  logic [1:0]        command_i,
  input  logic [15:0]       request_bytes_i,
  input  logic [15:0]       align_bytes_i,
  input  logic [11:0]       release_unit_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [1:0]        status_o,
  output logic [11:0]       data_unit_o,
  output logic [16:0]       used_bytes_o,
  output logic [16:0]       idle_bytes_o
);
  import ffha_pkg::*;

  localparam int unsigned AW = $clog2(POOL_UNITS);
  localparam int unsigned UW = AW + 1;
  localparam int unsigned EW = UW + 2;
  localparam int unsigned XW = ((UW > 16) ? UW : 16) + 2;
  localparam int unsigned BW = $clog2(UNIT_BYTES + 1);
  localparam int unsigned NW = 17;
  localparam int unsigned PW = UW + BW;
  localparam int unsigned SH = NW + $clog2(UNIT_BYTES);
  localparam int unsigned MW = NW + 2;
  localparam int unsigned QW = NW + MW;
  localparam logic [UW-1:0] POOL_SZ = UW'(POOL_UNITS);
  localparam logic [BW-1:0] UB_B = BW'(UNIT_BYTES);
  // Rounded-up reciprocal of the unit size; exact for every 17-bit dividend.
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(UNIT_BYTES) - 64'd1) / 64'(UNIT_BYTES));

  // Memory ports
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [EW-1:0] rd_data;

  // Control registers
  logic [AW-1:0] clr_q;
  logic          out_valid_q;

  // Payload registers
  cmd_e          cmd_q;
  logic          align_bad_q;
  logic          rel_bad_q;
  logic [XW-1:0] am_q;
  logic [NW-1:0] num_q;
  logic [XW-1:0] need_q;
  logic [UW-1:0] u_q;
  logic [UW-1:0] space_q;
  logic [UW-1:0] cur_sz_q;
  logic          cur_v_q;
  logic [UW-1:0] h_q;
  logic [UW-1:0] hsz_q;
  logic [UW-1:0] q_q;
  logic [UW-1:0] p_q;
  logic          p_v_q;
  logic          p_used_q;
  logic [UW-1:0] p_sz_q;
  logic [UW-1:0] used_u_q;
  logic [UW-1:0] idle_u_q;
  status_e       res_status_q;
  logic [11:0]   res_data_q;
  logic [16:0]   res_used_q;
  logic [16:0]   res_idle_q;
  status_e       out_status_q;
  logic [11:0]   out_data_q;
  logic [16:0]   out_used_q;
  logic [16:0]   out_idle_q;

  // Combinational helpers
  logic          rd_v;
  logic          rd_used;
  logic [UW-1:0] rd_sz;
  logic [UW-1:0] step;
  logic [XW-1:0] data_x;
  logic [XW-1:0] space_x;
  logic [QW-1:0] need_prod;
  logic [UW-1:0] lead_addr;
  logic [UW-1:0] tail_addr;
  logic [UW-1:0] data_u;
  logic [UW-1:0] p_merged;
  logic [PW-1:0] used_prod;
  logic [PW-1:0] idle_prod;
  logic          al_hit;
  logic [XW-1:0] al_am;
  logic          load_align_bad;
  logic          load_rel_bad;

  ffha_ram #(
    .WIDTH (EW),
    .DEPTH (POOL_UNITS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  assign rd_v    = rd_data[EW-1];
  assign rd_used = rd_data[EW-2];
  assign rd_sz   = rd_data[UW-1:0];
  assign step    = (rd_sz == '0) ? UW'(1) : rd_sz;

  // Gap in front of the data unit needed to reach the next aligned unit.
  assign data_x  = XW'(u_q) + XW'(1);
  assign space_x = ((data_x + am_q) & ~am_q) - data_x;

  // Units of data, rounded up, by multiplying with the reciprocal.
  assign need_prod = QW'(num_q) * QW'(RECIP);

  assign lead_addr = u_q + space_q;
  assign tail_addr = u_q + UW'(need_q);
  assign data_u    = u_q + UW'(1);
  assign p_merged  = p_sz_q + hsz_q;
  assign used_prod = PW'(used_u_q) * PW'(UB_B);
  assign idle_prod = PW'(idle_u_q) * PW'(UB_B);

  // The alignment is valid when it equals the unit size times a power of two.
  always_comb begin
    al_hit = 1'b0;
    al_am  = '0;
    for (int k = 0; k < 16; k++) begin
      if (((UNIT_BYTES << k) < 65536) && (32'(align_bytes_i) == (UNIT_BYTES << k))) begin
        al_hit = 1'b1;
        al_am  = XW'((1 << k) - 1);
      end
    end
  end

  assign load_align_bad = (cmd_e'(command_i) == CMD_ALIGNED) && !al_hit;
  assign load_rel_bad   = (release_unit_i == '0) || (32'(release_unit_i) > POOL_UNITS);

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    re    = 1'b0;
    raddr = '0;
    case (cmd_i.op)
      OP_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = (clr_q == '0) ? {1'b1, 1'b0, POOL_SZ} : '0;
      end
      OP_RD_U, OP_RD_N: begin
        re    = 1'b1;
        raddr = u_q[AW-1:0];
      end
      OP_WR_LEAD_REST: begin
        we    = 1'b1;
        waddr = lead_addr[AW-1:0];
        wdata = {1'b1, 1'b0, cur_sz_q - space_q};
      end
      OP_WR_LEAD_HDR: begin
        we    = 1'b1;
        waddr = u_q[AW-1:0];
        wdata = {cur_v_q, 1'b0, space_q};
      end
      OP_WR_TAIL: begin
        we    = 1'b1;
        waddr = tail_addr[AW-1:0];
        wdata = {1'b1, 1'b0, cur_sz_q - UW'(need_q)};
      end
      OP_WR_USED: begin
        we    = 1'b1;
        waddr = u_q[AW-1:0];
        wdata = {cur_v_q, 1'b1, cur_sz_q};
      end
      OP_RD_H: begin
        re    = 1'b1;
        raddr = h_q[AW-1:0];
      end
      OP_MERGE_N: begin
        we    = 1'b1;
        waddr = u_q[AW-1:0];
      end
      OP_RD_Q: begin
        re    = 1'b1;
        raddr = q_q[AW-1:0];
      end
      OP_WR_P: begin
        we    = 1'b1;
        waddr = p_q[AW-1:0];
        wdata = {p_v_q, 1'b0, p_merged};
      end
      OP_CLR_H: begin
        we    = 1'b1;
        waddr = h_q[AW-1:0];
      end
      OP_WR_H: begin
        we    = 1'b1;
        waddr = h_q[AW-1:0];
        wdata = {1'b1, 1'b0, hsz_q};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        cmd_q       <= cmd_e'(command_i);
        align_bad_q <= load_align_bad;
        rel_bad_q   <= load_rel_bad;
        am_q        <= (cmd_e'(command_i) == CMD_ALIGNED) ? al_am : '0;
        num_q       <= NW'(request_bytes_i) + NW'(UNIT_BYTES - 1);
        u_q         <= '0;
        q_q         <= '0;
        p_q         <= '0;
        h_q         <= UW'(release_unit_i - 12'd1);
        used_u_q    <= '0;
        idle_u_q    <= '0;
        res_data_q  <= '0;
        res_used_q  <= '0;
        res_idle_q  <= '0;
        if (load_align_bad) begin
          res_status_q <= ST_BADALIGN;
        end else if ((cmd_e'(command_i) == CMD_FREE) && load_rel_bad) begin
          res_status_q <= ST_BADFREE;
        end else begin
          res_status_q <= ST_OK;
        end
      end
      OP_NEED: begin
        need_q <= XW'(need_prod[QW-1:SH]) + XW'(1);
      end
      OP_STEP_U: begin
        u_q <= u_q + step;
      end
      OP_NOMEM: begin
        res_status_q <= ST_NOMEM;
      end
      OP_ALLOC_HIT: begin
        space_q  <= UW'(space_x);
        cur_sz_q <= rd_sz;
        cur_v_q  <= rd_v;
      end
      OP_WR_LEAD_HDR: begin
        u_q      <= lead_addr;
        cur_sz_q <= cur_sz_q - space_q;
        cur_v_q  <= 1'b1;
      end
      OP_WR_TAIL: begin
        cur_sz_q <= UW'(need_q);
      end
      OP_WR_USED: begin
        res_data_q <= 12'(data_u);
      end
      OP_BADFREE: begin
        res_status_q <= ST_BADFREE;
      end
      OP_H_HIT: begin
        hsz_q <= rd_sz;
        u_q   <= h_q + rd_sz;
      end
      OP_MERGE_N: begin
        hsz_q <= hsz_q + rd_sz;
      end
      OP_RD_Q: begin
        p_q <= q_q;
      end
      OP_STEP_Q: begin
        p_v_q    <= rd_v;
        p_used_q <= rd_used;
        p_sz_q   <= rd_sz;
        q_q      <= q_q + step;
      end
      OP_ACC: begin
        if (rd_used) begin
          used_u_q <= used_u_q + rd_sz;
        end else begin
          idle_u_q <= idle_u_q + rd_sz;
        end
        u_q <= u_q + step;
      end
      OP_TOTALS: begin
        res_used_q <= 17'(used_prod);
        res_idle_q <= 17'(idle_prod);
      end
      OP_EMIT: begin
        out_status_q <= res_status_q;
        out_data_q   <= res_data_q;
        out_used_q   <= res_used_q;
        out_idle_q   <= res_idle_q;
      end
      default: begin
        need_q <= need_q;
      end
    endcase
  end

  always_comb begin
    stat_o.cmd        = cmd_q;
    stat_o.align_bad  = align_bad_q;
    stat_o.rel_bad    = rel_bad_q;
    stat_o.u_end      = (u_q >= POOL_SZ);
    stat_o.fit        = !rd_used && (XW'(rd_sz) >= (need_q + space_x));
    stat_o.space_nz   = (space_q != '0);
    stat_o.tail_split = (XW'(cur_sz_q) >= (need_q + XW'(1)));
    stat_o.hdr_ok     = rd_v && rd_used;
    stat_o.n_in       = (u_q < POOL_SZ);
    stat_o.n_free     = rd_v && !rd_used;
    stat_o.h_zero     = (h_q == '0);
    stat_o.q_lt_h     = (q_q < h_q);
    stat_o.p_merge    = (q_q == h_q) && !p_used_q;
    stat_o.clr_last   = (clr_q == AW'(POOL_UNITS - 1));
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign data_unit_o  = out_data_q;
  assign used_bytes_o = out_used_q;
  assign idle_bytes_o = out_idle_q;

endmodule

/* sv/ffha_ctrl.sv */
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer for allocate, free and query walks over the block table.
// ----------------------------------------------------------------------------
module ffha_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ffha_pkg::dp_stat_t stat_i,
  output ffha_pkg::dp_cmd_t  cmd_o
);
  import ffha_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_DIV,
    S_A_RD,
    S_A_CHK,
    S_A_LEAD,
    S_A_LEADH,
    S_A_TAIL,
    S_A_USED,
    S_H_RD,
    S_H_CHK,
    S_N_RD,
    S_N_CHK,
    S_P_RD,
    S_P_CHK,
    S_P_MERGE,
    S_H_CLR,
    S_H_WR,
    S_Q_RD,
    S_Q_ACC,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   in_stall_q;
  dp_op_e op;

  always_comb begin
    state_d = state_q;
    op      = OP_NONE;
    case (state_q)
      S_CLEAR: begin
        op = OP_CLEAR;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op      = OP_LOAD;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat_i.cmd)
          CMD_ALLOC, CMD_ALIGNED: state_d = stat_i.align_bad ? S_DONE : S_DIV;
          CMD_FREE:               state_d = stat_i.rel_bad ? S_DONE : S_H_RD;
          default:                state_d = S_Q_RD;
        endcase
      end
      S_DIV: begin
        op      = OP_NEED;
        state_d = S_A_RD;
      end
      S_A_RD: begin
        if (stat_i.u_end) begin
          op      = OP_NOMEM;
          state_d = S_DONE;
        end else begin
          op      = OP_RD_U;
          state_d = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (stat_i.fit) begin
          op      = OP_ALLOC_HIT;
          state_d = S_A_LEAD;
        end else begin
          op      = OP_STEP_U;
          state_d = S_A_RD;
        end
      end
      S_A_LEAD: begin
        if (stat_i.space_nz) begin
          op      = OP_WR_LEAD_REST;
          state_d = S_A_LEADH;
        end else begin
          state_d = S_A_TAIL;
        end
      end
      S_A_LEADH: begin
        op      = OP_WR_LEAD_HDR;
        state_d = S_A_TAIL;
      end
      S_A_TAIL: begin
        if (stat_i.tail_split) begin
          op = OP_WR_TAIL;
        end
        state_d = S_A_USED;
      end
      S_A_USED: begin
        op      = OP_WR_USED;
        state_d = S_DONE;
      end
      S_H_RD: begin
        op      = OP_RD_H;
        state_d = S_H_CHK;
      end
      S_H_CHK: begin
        if (stat_i.hdr_ok) begin
          op      = OP_H_HIT;
          state_d = S_N_RD;
        end else begin
          op      = OP_BADFREE;
          state_d = S_DONE;
        end
      end
      S_N_RD: begin
        if (stat_i.n_in) begin
          op      = OP_RD_N;
          state_d = S_N_CHK;
        end else begin
          state_d = stat_i.h_zero ? S_H_WR : S_P_RD;
        end
      end
      S_N_CHK: begin
        if (stat_i.n_free) begin
          op = OP_MERGE_N;
        end
        state_d = stat_i.h_zero ? S_H_WR : S_P_RD;
      end
      S_P_RD: begin
        // Walk from the pool start to find the block just in front.
        if (stat_i.q_lt_h) begin
          op      = OP_RD_Q;
          state_d = S_P_CHK;
        end else if (stat_i.p_merge) begin
          state_d = S_P_MERGE;
        end else begin
          state_d = S_H_WR;
        end
      end
      S_P_CHK: begin
        op      = OP_STEP_Q;
        state_d = S_P_RD;
      end
      S_P_MERGE: begin
        op      = OP_WR_P;
        state_d = S_H_CLR;
      end
      S_H_CLR: begin
        op      = OP_CLR_H;
        state_d = S_DONE;
      end
      S_H_WR: begin
        op      = OP_WR_H;
        state_d = S_DONE;
      end
      S_Q_RD: begin
        if (stat_i.u_end) begin
          op      = OP_TOTALS;
          state_d = S_DONE;
        end else begin
          op      = OP_RD_U;
          state_d = S_Q_ACC;
        end
      end
      S_Q_ACC: begin
        op      = OP_ACC;
        state_d = S_Q_RD;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          op      = OP_EMIT;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      in_stall_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_stall_q <= (state_d != S_IDLE);
    end
  end

  assign in_stall_o = in_stall_q;
  assign cmd_o.op   = op;

endmodule

/* sv/first_fit_heap_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator with block splitting and coalescing on free.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                  Payload
// in       to block   in_valid_i / in_stall_o    command, request, align, release unit
// out      from block out_valid_o / out_stall_i  status, data unit, used and idle bytes
//
// After reset the block table is swept once, one entry per cycle, and no item
// is taken until the sweep is done.
// Allocate walks the block headers from the pool start; free walks the blocks
// in front of the freed one and merges with free neighbours; query visits
// every block. The walk reads one header per table read.
// A finished result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
  parameter int unsigned POOL_UNITS = ffha_pkg::POOL_UNITS_DEF,
  parameter int unsigned UNIT_BYTES = ffha_pkg::UNIT_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] request_bytes_i,
  input  logic [15:0] align_bytes_i,
  input  logic [11:0] release_unit_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [11:0] data_unit_o,
  output logic [16:0] used_bytes_o,
  output logic [16:0] idle_bytes_o
);
  import ffha_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  ffha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  ffha_datapath #(
    .POOL_UNITS (POOL_UNITS),
    .UNIT_BYTES (UNIT_BYTES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .stat_o          (dp_stat),
    .command_i       (command_i),
    .request_bytes_i (request_bytes_i),
    .align_bytes_i   (align_bytes_i),
    .release_unit_i  (release_unit_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .data_unit_o     (data_unit_o),
    .used_bytes_o    (used_bytes_o),
    .idle_bytes_o    (idle_bytes_o)
  );

endmodule

/* sv/ffha_checker.sv */
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks for the first-fit heap allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_macros.svh"

module ffha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  command_i,
  input logic [15:0] request_bytes_i,
  input logic [15:0] align_bytes_i,
  input logic [11:0] release_unit_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [11:0] data_unit_o,
  input logic [16:0] used_bytes_o,
  input logic [16:0] idle_bytes_o
);
  import ffha_pkg::*;

  // The block works on one item at a time, so it is busy right after taking one.
  `FFHA_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // A failed item reports neither a data unit nor totals.
  `FFHA_ASSERT_NOW(a_fail_is_empty, clk_i, rst_ni, out_valid_o && (status_o != ST_OK), (data_unit_o == '0) && (used_bytes_o == '0) && (idle_bytes_o == '0))

  // An allocation result carries no totals.
  `FFHA_ASSERT_NOW(a_alloc_no_totals, clk_i, rst_ni, out_valid_o && (status_o == ST_OK) && (data_unit_o != '0), (used_bytes_o == '0) && (idle_bytes_o == '0))

  `FFHA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(data_unit_o) && $stable(used_bytes_o) && $stable(idle_bytes_o))

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);
